[rtl/ers_pkg.sv]
// Shared types and constants for the extent read splitter.
package ers_pkg;

   // Field widths fixed by the item format
   localparam int OP_W         = 2;
   localparam int EXT_IDX_W    = 4;
   localparam int START_W      = 32;
   localparam int BLOCKS_W     = 24;
   localparam int OFFSET_W     = 48;
   localparam int ADDR_W       = 48;
   localparam int SEG_LEN_W    = 25;
   localparam int DEST_W       = 48;
   localparam int COUNT_W      = 5;
   localparam int REQ_TDATA_W  = 112;
   localparam int RSP_TDATA_W  = 128;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 25;
   localparam int WIDE_IDX_W   = 8;

   // Segments emitted per translate before it is cut off
   localparam int SEG_CNT_W    = 5;
   localparam logic [SEG_CNT_W-1:0] MAX_SEGS = 5'd16;

   localparam logic [CSR_DATA_W-1:0] READ_SIZE_RESET = 25'd4096;

   localparam logic [CSR_IDX_W-1:0] CSR_READ_SIZE    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_EXTENT_COUNT = 1'b1;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD      = 2'd0,
      OP_TRANSLATE = 2'd1,
      OP_CLEAR     = 2'd2
   } op_type;

   // Controller to datapath
   typedef struct packed {
      logic start;      // latch offset and read size, restart the walk
      logic load;       // write one table entry
      logic clear;      // zero the running destination offset
      logic mul;        // scale the table entry to bytes
      logic walk_step;  // skip a whole extent while searching
      logic seg_take;   // cut a segment into the pending slot
      logic dec;        // account for the pending segment
      logic advance;    // move to the next extent
      logic push_pend;  // transfer pending segment to the output register
      logic push_last;
      logic push_oor_bit;
      logic push_oor;   // transfer the offset-past-table result
   } ers_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic read_size_zero;
      logic limit_zero;
      logic dist_lt_le;
      logic found;
      logic pend_vld;
      logic want_eq_seg;
      logic at_end;
      logic seg_full;
      logic out_free;
   } ers_sts_type;

endpackage

[rtl/ers_ctrl.sv]
// Sequencer for table loads, the extent walk and segment emission.
module ers_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ers_pkg::OP_W-1:0]          req_op,
   input  ers_pkg::ers_sts_type              sts,
   output ers_pkg::ers_cmd_type              cmd
);
   import ers_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_RD    = 8'b0000_0010,
      ST_MUL   = 8'b0000_0100,
      ST_CMP   = 8'b0000_1000,
      ST_DEC   = 8'b0001_0000,
      ST_FLUSH = 8'b0010_0000,
      ST_FIN   = 8'b0100_0000,
      ST_OOR   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      fin_oor_ff, fin_oor_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      fin_oor_in = fin_oor_ff;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               case (req_op)
                  OP_LOAD:  cmd.load  = 1'b1;
                  OP_CLEAR: cmd.clear = 1'b1;
                  OP_TRANSLATE: begin
                     if (!sts.read_size_zero) begin
                        cmd.start = 1'b1;
                        state_in  = sts.limit_zero ? ST_OOR : ST_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_RD:  state_in = ST_MUL;
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (!sts.found && !sts.dist_lt_le) begin
               cmd.walk_step = 1'b1;
               state_in      = sts.at_end ? ST_OOR : ST_RD;
            end else if (sts.dist_lt_le) begin
               // hold the new segment until the previous one is out
               if (sts.pend_vld) begin
                  state_in = ST_FLUSH;
               end else begin
                  cmd.seg_take = 1'b1;
                  state_in     = ST_DEC;
               end
            end else if (sts.at_end) begin
               // empty extent at the end: previous segment closes the read
               fin_oor_in = 1'b1;
               state_in   = ST_FIN;
            end else begin
               cmd.advance = 1'b1;
               state_in    = ST_RD;
            end
         end
         ST_DEC: begin
            cmd.dec = 1'b1;
            if (sts.want_eq_seg) begin
               fin_oor_in = 1'b0;
               state_in   = ST_FIN;
            end else if (sts.at_end || sts.seg_full) begin
               fin_oor_in = 1'b1;
               state_in   = ST_FIN;
            end else begin
               cmd.advance = 1'b1;
               state_in    = ST_RD;
            end
         end
         ST_FLUSH: begin
            if (sts.out_free) begin
               cmd.push_pend = 1'b1;
               state_in      = ST_CMP;
            end
         end
         ST_FIN: begin
            if (sts.out_free) begin
               cmd.push_pend    = 1'b1;
               cmd.push_last    = 1'b1;
               cmd.push_oor_bit = fin_oor_ff;
               state_in         = ST_IDLE;
            end
         end
         ST_OOR: begin
            if (sts.out_free) begin
               cmd.push_oor = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         fin_oor_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         fin_oor_ff <= fin_oor_in;
      end
   end

endmodule

[rtl/ers_dpath.sv]
// Extent table, walk arithmetic, pending segment and output register.
module ers_dpath #(
   parameter int MAX_EXTENTS = 16,
   parameter int BLOCK_BYTES = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ers_pkg::ers_cmd_type                cmd,
   output ers_pkg::ers_sts_type                sts,
   input  logic [ers_pkg::EXT_IDX_W-1:0]       req_extent_index,
   input  logic [ers_pkg::START_W-1:0]         req_start_block,
   input  logic [ers_pkg::BLOCKS_W-1:0]        req_blocks,
   input  logic [ers_pkg::OFFSET_W-1:0]        req_file_offset,
   input  logic                                csr_wen,
   input  logic [ers_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ers_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic [ers_pkg::ADDR_W-1:0]          rsp_device_address,
   output logic [ers_pkg::SEG_LEN_W-1:0]       rsp_segment_length,
   output logic [ers_pkg::DEST_W-1:0]          rsp_dest_offset,
   output logic                                rsp_last,
   output logic                                rsp_out_of_range
);
   import ers_pkg::*;

   localparam int AW        = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
   localparam int MEM_DEPTH = 1 << AW;
   localparam int CW        = $clog2(MAX_EXTENTS + 1);
   localparam int LE_W      = BLOCKS_W + $clog2(BLOCK_BYTES + 1);

   // Extent table, contents undefined until loaded
   logic [START_W-1:0]  start_mem [MEM_DEPTH];
   logic [BLOCKS_W-1:0] len_mem   [MEM_DEPTH];
   logic [START_W-1:0]  start_q;
   logic [BLOCKS_W-1:0] len_q;

   logic [WIDE_IDX_W-1:0] wide_idx;
   logic                  load_ok;
   logic [AW-1:0]         waddr;
   logic [AW-1:0]         raddr;

   logic [CSR_DATA_W-1:0] read_size_ff, read_size_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [WIDE_IDX_W-1:0] count_wide, limit_wide;
   logic [CW-1:0]         limit;

   logic [OFFSET_W-1:0]   dist_ff, dist_in;
   logic [SEG_LEN_W-1:0]  want_ff, want_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic [SEG_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                  found_ff, found_in;
   logic [DEST_W-1:0]     rdo_ff, rdo_in;
   logic [LE_W-1:0]       le_ff, le_in;
   logic [ADDR_W-1:0]     base_ff, base_in;

   logic [ADDR_W-1:0]     pend_addr_ff, pend_addr_in;
   logic [SEG_LEN_W-1:0]  pend_len_ff, pend_len_in;
   logic [DEST_W-1:0]     pend_dest_ff, pend_dest_in;
   logic                  pend_vld_ff, pend_vld_in;

   logic                  rsp_vld_ff, rsp_vld_in;
   logic [ADDR_W-1:0]     rsp_addr_ff, rsp_addr_in;
   logic [SEG_LEN_W-1:0]  rsp_len_ff, rsp_len_in;
   logic [DEST_W-1:0]     rsp_dest_ff, rsp_dest_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_oor_ff, rsp_oor_in;

   logic [OFFSET_W-1:0]   le_ext;
   logic [OFFSET_W-1:0]   left;
   logic [SEG_LEN_W-1:0]  seg;
   logic                  out_free;

   assign wide_idx = WIDE_IDX_W'(req_extent_index);
   assign load_ok  = wide_idx < WIDE_IDX_W'(MAX_EXTENTS);
   assign waddr    = wide_idx[AW-1:0];
   assign raddr    = AW'(idx_ff);

   always_ff @(posedge clock) begin
      if (cmd.load && load_ok) begin
         start_mem[waddr] <= req_start_block;
         len_mem[waddr]   <= req_blocks;
      end
      start_q <= start_mem[raddr];
      len_q   <= len_mem[raddr];
   end

   // Counts above the table depth saturate
   assign count_wide = WIDE_IDX_W'(count_ff);
   assign limit_wide = (count_wide > WIDE_IDX_W'(MAX_EXTENTS)) ?
                       WIDE_IDX_W'(MAX_EXTENTS) : count_wide;
   assign limit      = limit_wide[CW-1:0];

   assign le_ext   = OFFSET_W'(le_ff);
   assign left     = le_ext - dist_ff;
   assign seg      = (left < OFFSET_W'(want_ff)) ? left[SEG_LEN_W-1:0] : want_ff;
   assign out_free = !rsp_vld_ff || rsp_tready;

   always_comb begin
      read_size_in = read_size_ff;
      count_in     = count_ff;
      dist_in      = dist_ff;
      want_in      = want_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      found_in     = found_ff;
      rdo_in       = rdo_ff;
      le_in        = le_ff;
      base_in      = base_ff;
      pend_addr_in = pend_addr_ff;
      pend_len_in  = pend_len_ff;
      pend_dest_in = pend_dest_ff;
      pend_vld_in  = pend_vld_ff;
      rsp_vld_in   = rsp_vld_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_dest_in  = rsp_dest_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_oor_in   = rsp_oor_ff;

      if (csr_wen) begin
         case (csr_index)
            CSR_READ_SIZE:    read_size_in = csr_wdata;
            CSR_EXTENT_COUNT: count_in     = csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end

      if (cmd.start) begin
         dist_in     = req_file_offset;
         want_in     = read_size_ff;
         idx_in      = '0;
         cnt_in      = '0;
         found_in    = 1'b0;
         pend_vld_in = 1'b0;
      end
      if (cmd.clear) begin
         rdo_in = '0;
      end
      if (cmd.mul) begin
         le_in   = LE_W'(64'(len_q) * 64'(BLOCK_BYTES));
         base_in = ADDR_W'(64'(start_q) * 64'(BLOCK_BYTES));
      end
      if (cmd.walk_step) begin
         dist_in = dist_ff - le_ext;
         idx_in  = idx_ff + CW'(1);
      end
      if (cmd.seg_take) begin
         pend_len_in  = seg;
         pend_addr_in = base_ff + dist_ff;
         pend_dest_in = rdo_ff;
         pend_vld_in  = 1'b1;
         dist_in      = '0;
         found_in     = 1'b1;
         cnt_in       = cnt_ff + SEG_CNT_W'(1);
      end
      if (cmd.dec) begin
         rdo_in  = rdo_ff + DEST_W'(pend_len_ff);
         want_in = want_ff - pend_len_ff;
      end
      if (cmd.advance) begin
         idx_in = idx_ff + CW'(1);
      end

      if (cmd.push_pend) begin
         rsp_vld_in  = 1'b1;
         rsp_addr_in = pend_addr_ff;
         rsp_len_in  = pend_len_ff;
         rsp_dest_in = pend_dest_ff;
         rsp_last_in = cmd.push_last;
         rsp_oor_in  = cmd.push_oor_bit;
         pend_vld_in = 1'b0;
      end else if (cmd.push_oor) begin
         rsp_vld_in  = 1'b1;
         rsp_addr_in = '0;
         rsp_len_in  = '0;
         rsp_dest_in = rdo_ff;
         rsp_last_in = 1'b1;
         rsp_oor_in  = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_size_ff <= READ_SIZE_RESET;
         count_ff     <= '0;
         rdo_ff       <= '0;
         pend_vld_ff  <= 1'b0;
         rsp_vld_ff   <= 1'b0;
         found_ff     <= 1'b0;
         idx_ff       <= '0;
         cnt_ff       <= '0;
      end else begin
         read_size_ff <= read_size_in;
         count_ff     <= count_in;
         rdo_ff       <= rdo_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_vld_ff   <= rsp_vld_in;
         found_ff     <= found_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
      end
      dist_ff      <= dist_in;
      want_ff      <= want_in;
      le_ff        <= le_in;
      base_ff      <= base_in;
      pend_addr_ff <= pend_addr_in;
      pend_len_ff  <= pend_len_in;
      pend_dest_ff <= pend_dest_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_dest_ff  <= rsp_dest_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_oor_ff   <= rsp_oor_in;
   end

   assign sts.read_size_zero = (read_size_ff == '0);
   assign sts.limit_zero     = (limit == '0);
   assign sts.dist_lt_le     = dist_ff < le_ext;
   assign sts.found          = found_ff;
   assign sts.pend_vld       = pend_vld_ff;
   assign sts.want_eq_seg    = (want_ff == pend_len_ff);
   assign sts.at_end         = (idx_ff + CW'(1)) >= limit;
   assign sts.seg_full       = cnt_ff >= MAX_SEGS;
   assign sts.out_free       = out_free;

   assign rsp_tvalid         = rsp_vld_ff;
   assign rsp_device_address = rsp_addr_ff;
   assign rsp_segment_length = rsp_len_ff;
   assign rsp_dest_offset    = rsp_dest_ff;
   assign rsp_last           = rsp_last_ff;
   assign rsp_out_of_range   = rsp_oor_ff;

endmodule

[rtl/extent_read_splitter_unit.sv]
// Top level of the extent read splitter: file offset to device read segments.
// Load and clear items are carried out at their transfer. A translate walks
// the extent table in order; for each entry visited, one registered table
// read and one multiply stage scale the block count to bytes, then a compare
// follows. Each segment is then accounted in its own step. Before every
// segment after the first, the previous segment moves into the output
// register and the compare is repeated. The final segment then moves to the
// output register. An offset past the table yields a single out-of-range
// result. A move into the output register waits while that register still
// holds a segment not yet taken by rsp_tready. One translate is in work at a
// time. The next request is taken as soon as the last segment sits in the
// output register, even while that segment still waits for rsp_tready.
module extent_read_splitter_unit #(
   parameter int MAX_EXTENTS = 16,
   parameter int BLOCK_BYTES = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // extent_index[3:0], extent_start_block[35:4], extent_blocks[59:36],
   // file_offset[107:60], zero fill[111:108]
   input  logic [ers_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // operation[1:0]
   input  logic [ers_pkg::OP_W-1:0]            req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // device_address[47:0], segment_length[72:48], dest_offset[120:73],
   // zero fill[127:121]
   output logic [ers_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,
   // out_of_range[0]
   output logic                                rsp_tuser,
   input  logic                                csr_wen,
   input  logic [ers_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ers_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import ers_pkg::*;

   ers_cmd_type cmd;
   ers_sts_type sts;

   logic [ADDR_W-1:0]    rsp_device_address;
   logic [SEG_LEN_W-1:0] rsp_segment_length;
   logic [DEST_W-1:0]    rsp_dest_offset;

   ers_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .sts        (sts),
      .cmd        (cmd)
   );

   ers_dpath #(
      .MAX_EXTENTS (MAX_EXTENTS),
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_extent_index   (req_tdata[3:0]),
      .req_start_block    (req_tdata[35:4]),
      .req_blocks         (req_tdata[59:36]),
      .req_file_offset    (req_tdata[107:60]),
      .csr_wen            (csr_wen),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_tready         (rsp_tready),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_device_address (rsp_device_address),
      .rsp_segment_length (rsp_segment_length),
      .rsp_dest_offset    (rsp_dest_offset),
      .rsp_last           (rsp_tlast),
      .rsp_out_of_range   (rsp_tuser)
   );

   assign rsp_tdata = {7'b0, rsp_dest_offset, rsp_segment_length, rsp_device_address};

endmodule

[test/extent_read_checker.sv]
`timescale 1ns / 1ps
// Checker for the extent read splitter: tracks table and registers, predicts and compares segments.
module extent_read_checker #(
   parameter int MAX_EXTENTS = 16,
   parameter int BLOCK_BYTES = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [ers_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic [ers_pkg::OP_W-1:0]          req_tuser,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [ers_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                              rsp_tlast,
   input  logic                              rsp_tuser,
   input  logic                              csr_wen,
   input  logic [ers_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ers_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output int                                failures,
   output int                                outstanding
);
   import ers_pkg::*;

   localparam int START_LSB  = EXT_IDX_W;
   localparam int BLOCKS_LSB = EXT_IDX_W + START_W;
   localparam int OFFSET_LSB = EXT_IDX_W + START_W + BLOCKS_W;
   localparam int LEN_LSB    = ADDR_W;
   localparam int DEST_LSB   = ADDR_W + SEG_LEN_W;

   typedef struct packed {
      logic [ADDR_W-1:0]    address;
      logic [SEG_LEN_W-1:0] length;
      logic [DEST_W-1:0]    dest;
      logic                 last;
      logic                 oor;
   } read_segment_type;

   logic [START_W-1:0]    start_blocks   [MAX_EXTENTS];
   logic [BLOCKS_W-1:0]   extent_lengths [MAX_EXTENTS];
   logic [CSR_DATA_W-1:0] read_size;
   logic [COUNT_W-1:0]    extent_count;
   logic [DEST_W-1:0]     dest_cursor;
   read_segment_type      expected_segments [$];
   int                    mismatches;

   // Walk the valid extents to the one holding the offset, then cut segments
   // until the read size is covered, the table ends or the segment cap is hit.
   task automatic split_translate(input logic [OFFSET_W-1:0] offset);
      logic [63:0]      rel_offset, ext_bytes, want, left, take;
      int               limit, idx, nseg;
      read_segment_type batch [16];
      want = 64'(read_size);
      if (want == 0) return;
      limit = (int'(extent_count) > MAX_EXTENTS) ? MAX_EXTENTS : int'(extent_count);
      rel_offset = 64'(offset);
      idx = 0;
      while (idx < limit) begin
         ext_bytes = 64'(extent_lengths[idx]) * 64'(BLOCK_BYTES);
         if (rel_offset < ext_bytes) break;
         rel_offset -= ext_bytes;
         idx++;
      end
      if (idx >= limit) begin
         expected_segments.push_back('{address: '0, length: '0, dest: dest_cursor,
                                        last: 1'b1, oor: 1'b1});
         return;
      end
      nseg = 0;
      forever begin
         ext_bytes = 64'(extent_lengths[idx]) * 64'(BLOCK_BYTES);
         // skip zero-length extents without a segment
         if (ext_bytes > rel_offset) begin
            left = ext_bytes - rel_offset;
            take = (left < want) ? left : want;
            batch[nseg].address = ADDR_W'(64'(start_blocks[idx]) * 64'(BLOCK_BYTES)
                                          + rel_offset);
            batch[nseg].length  = SEG_LEN_W'(take);
            batch[nseg].dest    = dest_cursor;
            batch[nseg].last    = 1'b0;
            batch[nseg].oor     = 1'b0;
            dest_cursor = dest_cursor + DEST_W'(take);
            want -= take;
            nseg++;
         end
         rel_offset = 0;
         if (want == 0) begin
            batch[nseg-1].last = 1'b1;
            break;
         end
         if (idx + 1 >= limit || nseg >= int'(MAX_SEGS)) begin
            batch[nseg-1].last = 1'b1;
            batch[nseg-1].oor  = 1'b1;
            break;
         end
         idx++;
      end
      for (int k = 0; k < nseg; k++) expected_segments.push_back(batch[k]);
   endtask

   task automatic check_field(input string name, input logic [63:0] exp_v,
                              input logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      read_segment_type seg;
      if (reset) begin
         read_size    = READ_SIZE_RESET;
         extent_count = '0;
         dest_cursor  = '0;
         expected_segments.delete();
         mismatches   = 0;
      end else begin
         if (csr_wen) begin
            if (csr_index == CSR_READ_SIZE) read_size = csr_wdata;
            else if (csr_index == CSR_EXTENT_COUNT) extent_count = csr_wdata[COUNT_W-1:0];
         end
         // compare first: a segment leaving now never belongs to a request arriving now
         if (rsp_tvalid && rsp_tready) begin
            if (expected_segments.size() == 0) begin
               $display("%0t: segment transfer with none expected, expected none, actual %h %b %b",
                        $time, rsp_tdata, rsp_tlast, rsp_tuser);
               mismatches++;
            end else begin
               seg = expected_segments.pop_front();
               check_field("device_address", 64'(seg.address), 64'(rsp_tdata[ADDR_W-1:0]));
               check_field("segment_length", 64'(seg.length),
                           64'(rsp_tdata[LEN_LSB +: SEG_LEN_W]));
               check_field("dest_offset", 64'(seg.dest), 64'(rsp_tdata[DEST_LSB +: DEST_W]));
               check_field("last", 64'(seg.last), 64'(rsp_tlast));
               check_field("out_of_range", 64'(seg.oor), 64'(rsp_tuser));
            end
         end
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               OP_LOAD: begin
                  start_blocks[req_tdata[EXT_IDX_W-1:0]]   = req_tdata[START_LSB +: START_W];
                  extent_lengths[req_tdata[EXT_IDX_W-1:0]] = req_tdata[BLOCKS_LSB +: BLOCKS_W];
               end
               OP_TRANSLATE: split_translate(req_tdata[OFFSET_LSB +: OFFSET_W]);
               OP_CLEAR: dest_cursor = '0;
               default: ;
            endcase
         end
      end
      failures    <= mismatches;
      outstanding <= expected_segments.size();
   end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// Top of the extent read splitter testbench: stimulus, flow control and verdict.
module testbench;
   import ers_pkg::*;

   localparam logic [OP_W-1:0]       OP_UNUSED     = 2'd3;
   localparam int                    NUM_EXTENTS   = 16;
   localparam int                    BLOCK_BYTES   = 4096;
   localparam int                    SETTLE_CYCLES = 100;
   localparam int                    CYCLE_LIMIT   = 2_000_000;
   localparam logic [CSR_DATA_W-1:0] MAX_READ      = 25'd16777216;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [OP_W-1:0]        req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic                   rsp_tuser;
   logic                   csr_wen;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     failures;
   int                     outstanding;

   bit                     steady;
   logic [BLOCKS_W-1:0]    shadow_blocks [NUM_EXTENTS];
   int                     active_extents;

   extent_read_splitter_unit dut (.*);
   extent_read_checker segment_check (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [OFFSET_W-1:0] random48();
      return {16'($urandom), $urandom};
   endfunction

   // bytes covered by the extents that currently count as valid
   function automatic logic [63:0] table_bytes();
      logic [63:0] span;
      span = 0;
      for (int i = 0; i < active_extents; i++)
         span += 64'(shadow_blocks[i]) * 64'(BLOCK_BYTES);
      return span;
   endfunction

   function automatic logic [OFFSET_W-1:0] pick_offset();
      logic [63:0] span;
      int          r;
      span = table_bytes();
      r = $urandom_range(0, 99);
      if (r < 80 && span != 0) return OFFSET_W'({$urandom, $urandom} % span);
      if (r < 90)
         return OFFSET_W'(span + $urandom_range(0, 8191) - ((span < 4096) ? span : 4096));
      return random48();
   endfunction

   function automatic logic [BLOCKS_W-1:0] pick_blocks();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return BLOCKS_W'($urandom_range(1, 4));
      if (r < 80) return '0;
      if (r < 95) return BLOCKS_W'($urandom_range(5, 64));
      return BLOCKS_W'($urandom);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_read_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 25'd1;
      if (r < 20) return MAX_READ;
      if (r < 30) return CSR_DATA_W'($urandom_range(1, 1 << 24));
      if (r < 45) return CSR_DATA_W'($urandom_range(60000, 80000));
      return CSR_DATA_W'($urandom_range(1, 40000));
   endfunction

   function automatic logic [COUNT_W-1:0] pick_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return '0;
      if (r < 20) return COUNT_W'($urandom_range(17, 31));
      if (r < 40) return COUNT_W'($urandom_range(1, 15));
      return COUNT_W'(NUM_EXTENTS);
   endfunction

   // Hold the item until its transfer, then maybe idle; valid stays high when no gap follows.
   task automatic send_item(input logic [OP_W-1:0] op, input logic [EXT_IDX_W-1:0] idx,
                            input logic [START_W-1:0] start, input logic [BLOCKS_W-1:0] blocks,
                            input logic [OFFSET_W-1:0] offset);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, offset, blocks, start, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      gap = idle_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic load_extent(input logic [EXT_IDX_W-1:0] idx, input logic [START_W-1:0] start,
                              input logic [BLOCKS_W-1:0] blocks);
      shadow_blocks[idx] = blocks;
      send_item(OP_LOAD, idx, start, blocks, random48());
   endtask

   task automatic translate_at(input logic [OFFSET_W-1:0] offset);
      send_item(OP_TRANSLATE, EXT_IDX_W'($urandom), $urandom, BLOCKS_W'($urandom), offset);
   endtask

   task automatic send_noise(input logic [OP_W-1:0] op);
      send_item(op, EXT_IDX_W'($urandom), $urandom, BLOCKS_W'($urandom), random48());
   endtask

   // Drop valid and wait until every predicted segment has been taken.
   task automatic wait_idle(input int settle);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic set_config(input logic [CSR_DATA_W-1:0] size, input logic [COUNT_W-1:0] count);
      wait_idle(SETTLE_CYCLES);
      csr_wen   <= 1'b1;
      csr_index <= CSR_READ_SIZE;
      csr_wdata <= size;
      @(posedge clock);
      // upper bits of the count word are junk the block must drop
      csr_index <= CSR_EXTENT_COUNT;
      csr_wdata <= {20'($urandom), count};
      @(posedge clock);
      csr_wen <= 1'b0;
      active_extents = (int'(count) > NUM_EXTENTS) ? NUM_EXTENTS : int'(count);
   endtask

   initial begin
      int hold;
      hold = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 2) == 0) hold = idle_gap();
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("%0t: timeout, %0d segments still expected", $time, outstanding);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      int r;
      steady         = 1'b1;
      active_extents = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      csr_wen    <= 1'b0;
      csr_index  <= '0;
      csr_wdata  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty table: offset past table, then a clear and an unused code
      translate_at('0);
      send_noise(OP_CLEAR);
      send_noise(OP_UNUSED);

      load_extent(4'd0, 32'hFFFF_FFFF, 24'd1);
      load_extent(4'd1, $urandom, 24'd0);
      load_extent(4'd2, $urandom, 24'hFF_FFFF);
      for (int i = 3; i < NUM_EXTENTS; i++)
         load_extent(EXT_IDX_W'(i), $urandom, BLOCKS_W'($urandom_range(1, 3)));

      set_config(25'(3 * BLOCK_BYTES + 100), COUNT_W'(NUM_EXTENTS));
      translate_at('0);
      translate_at(48'd4095);

      // count above the table size acts as a full table
      set_config(MAX_READ, 5'd31);
      translate_at(48'd4096);
      translate_at(48'hFFFF_FFFF_FFFF);
      translate_at(OFFSET_W'(64'(BLOCK_BYTES) + 64'h0FF_FFFF * 64'(BLOCK_BYTES) - 10));

      set_config('0, COUNT_W'(NUM_EXTENTS));
      translate_at('0);

      set_config(25'd1, COUNT_W'(NUM_EXTENTS));
      translate_at(48'd12345);

      // every extent non-empty: the read fills the segment cap exactly, then overruns by one
      load_extent(4'd1, $urandom, 24'd1);
      load_extent(4'd2, $urandom, 24'd1);
      active_extents = NUM_EXTENTS;
      set_config(CSR_DATA_W'(table_bytes()), COUNT_W'(NUM_EXTENTS));
      translate_at('0);
      translate_at(48'd1);

      for (int phase = 0; phase < 10; phase++) begin
         steady = (phase % 4 == 1);
         set_config(pick_read_size(), pick_count());
         for (int k = 0; k < 50; k++) begin
            if (k == 25 || $urandom_range(0, 39) == 0) wait_idle(0);
            r = $urandom_range(0, 99);
            if (r < 12) load_extent(EXT_IDX_W'($urandom), $urandom, pick_blocks());
            else if (r < 18) send_noise(OP_CLEAR);
            else if (r < 22) send_noise(OP_UNUSED);
            else translate_at(pick_offset());
         end
      end

      wait_idle(SETTLE_CYCLES);
      if (failures == 0 && outstanding == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

[filelist.f]
rtl/ers_pkg.sv
rtl/ers_ctrl.sv
rtl/ers_dpath.sv
rtl/extent_read_splitter_unit.sv
test/extent_read_checker.sv
test/testbench.sv
